[rtl/lzo_pkg.sv]
// Shared types and constants for the LZO1X stream decompressor.
// Used by lzo_parse, lzo_hist and lzo1x_stream_decompressor.
package lzo_pkg;

  localparam int WIN_BITS = 16;
  localparam int CNT_BITS = 24;
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_COPY    = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;
  localparam logic [1:0] CMD_ILLEGAL = 2'd3;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NOT_CONSUMED = 3'd1;
  localparam logic [2:0] ERR_OVERRUN      = 3'd2;
  localparam logic [2:0] ERR_MISUSE       = 3'd3;
  localparam logic [2:0] ERR_LOOKBEHIND   = 3'd4;
  localparam logic [2:0] ERR_LENGTH       = 3'd5;

  typedef enum logic [3:0] {
    PH_FIRST, PH_OP, PH_AFTER_RUN, PH_AFTER_SHORT, PH_LEXT, PH_LIT_RUN,
    PH_LIT_TRAIL, PH_M1_FAR, PH_M1_NEAR, PH_M2, PH_MEXT, PH_MLO, PH_MHI
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
    logic       last_byte;
  } cmd_t;

  typedef struct packed {
    logic                out_valid;
    logic [7:0]          out_byte;
    logic                want_input;
    logic                done_res;
    logic [2:0]          error_code;
    logic [CNT_BITS-1:0] out_count;
  } res_t;

  // parser result handed to the history stage
  typedef struct packed {
    logic                out_valid;
    logic                from_mem;
    logic [7:0]          lit_byte;
    logic [WIN_BITS-1:0] rd_addr;
    logic [WIN_BITS-1:0] wr_addr;
    logic                want_input;
    logic                done_res;
    logic [2:0]          error_code;
    logic [CNT_BITS-1:0] out_count;
  } pres_t;

endpackage

[rtl/lzo_parse.sv]
// Opcode parser and block state of the LZO1X decompressor.
// Depends on lzo_pkg.
module lzo_parse import lzo_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  acc,
  input  cmd_t  word,
  output pres_t pres
);

  logic [CNT_BITS-1:0] produced, produced_next;
  phase_t              phase, phase_next;
  logic [CNT_BITS-1:0] len, len_next;
  logic [WIN_BITS-1:0] match_dist, match_dist_next;
  logic [CNT_BITS-1:0] copy_rem, copy_rem_next;
  logic [1:0]          trail, trail_next;
  logic [7:0]          opcode, opcode_next;
  logic                finished, finished_next;
  logic [2:0]          err, err_next;
  logic                emit, from_mem;

  always_comb begin
    logic [7:0]          b, t;
    logic                do_match, fin, do_add;
    logic [16:0]         mdist;
    logic [CNT_BITS-1:0] mlen;
    logic [1:0]          mtrail;
    logic [CNT_BITS:0]   addv, sum;
    logic [13:0]         off;
    logic [14:0]         far;
    produced_next   = produced;
    phase_next      = phase;
    len_next        = len;
    match_dist_next = match_dist;
    copy_rem_next   = copy_rem;
    trail_next      = trail;
    opcode_next     = opcode;
    finished_next   = finished;
    err_next        = err;
    emit            = 1'b0;
    from_mem        = 1'b0;
    b               = word.in_byte;
    t               = opcode;
    do_match        = 1'b0;
    fin             = 1'b0;
    do_add          = 1'b0;
    mdist           = '0;
    mlen            = '0;
    mtrail          = '0;
    addv            = '0;
    off             = {b, match_dist[7:2]};
    far             = {t[3], off};
    sum             = '0;
    if (acc) begin
      if (word.command == CMD_START) begin
        produced_next   = '0;
        phase_next      = PH_FIRST;
        len_next        = '0;
        match_dist_next = '0;
        copy_rem_next   = '0;
        trail_next      = '0;
        opcode_next     = '0;
        finished_next   = 1'b0;
        err_next        = ERR_NONE;
      end else if (!finished && err == ERR_NONE) begin
        if (word.command == CMD_BYTE) begin
          if (copy_rem != '0) begin
            err_next = ERR_MISUSE;
          end else begin
            unique case (phase)
              PH_FIRST, PH_OP, PH_AFTER_RUN, PH_AFTER_SHORT: begin
                if (phase == PH_FIRST && b > 8'h11) begin
                  len_next   = CNT_BITS'(b - 8'h11);
                  phase_next = (b < 8'h15) ? PH_LIT_TRAIL : PH_LIT_RUN;
                end else begin
                  opcode_next = b;
                  if (b >= 8'd64) begin
                    phase_next = PH_M2;
                  end else if (b >= 8'd16) begin
                    if ((b[5] ? {3'b0, b[4:0]} : {5'b0, b[2:0]}) == 8'd0) begin
                      len_next   = '0;
                      phase_next = PH_MEXT;
                    end else begin
                      len_next   = b[5] ? CNT_BITS'(b[4:0]) + CNT_BITS'(2)
                                        : CNT_BITS'(b[2:0]) + CNT_BITS'(2);
                      phase_next = PH_MLO;
                    end
                  end else if (phase == PH_OP || phase == PH_FIRST) begin
                    if (b == 8'd0) begin
                      len_next   = '0;
                      phase_next = PH_LEXT;
                    end else begin
                      len_next   = CNT_BITS'(b) + CNT_BITS'(3);
                      phase_next = PH_LIT_RUN;
                    end
                  end else begin
                    phase_next = (phase == PH_AFTER_RUN) ? PH_M1_FAR : PH_M1_NEAR;
                  end
                end
              end
              PH_LEXT: begin
                do_add = 1'b1;
                if (b == 8'd0) begin
                  addv = (CNT_BITS+1)'(8'hff);
                end else begin
                  addv       = (CNT_BITS+1)'(b) + (CNT_BITS+1)'(18);
                  phase_next = PH_LIT_RUN;
                end
              end
              PH_LIT_RUN, PH_LIT_TRAIL: begin
                if (produced >= CNT_MAX) begin
                  err_next = ERR_LENGTH;
                end else begin
                  emit          = 1'b1;
                  produced_next = produced + 1'b1;
                  if (len != '0) len_next = len - 1'b1;
                  if (len <= CNT_BITS'(1))
                    phase_next = (phase == PH_LIT_RUN) ? PH_AFTER_RUN : PH_AFTER_SHORT;
                end
              end
              PH_M1_FAR: begin
                do_match = 1'b1;
                mdist    = 17'h801 + 17'(t[7:2]) + {7'b0, b, 2'b0};
                mlen     = CNT_BITS'(3);
                mtrail   = t[1:0];
              end
              PH_M1_NEAR: begin
                do_match = 1'b1;
                mdist    = 17'd1 + 17'(t[7:2]) + {7'b0, b, 2'b0};
                mlen     = CNT_BITS'(2);
                mtrail   = t[1:0];
              end
              PH_M2: begin
                do_match = 1'b1;
                mdist    = 17'd1 + 17'(t[4:2]) + {6'b0, b, 3'b0};
                mlen     = CNT_BITS'(t[7:5]) + 1'b1;
                mtrail   = t[1:0];
              end
              PH_MEXT: begin
                do_add = 1'b1;
                if (b == 8'd0) begin
                  addv = (CNT_BITS+1)'(8'hff);
                end else begin
                  addv = (CNT_BITS+1)'(b) +
                         ((t[7:5] != 3'd0) ? (CNT_BITS+1)'(33) : (CNT_BITS+1)'(9));
                  phase_next = PH_MLO;
                end
              end
              PH_MLO: begin
                match_dist_next = WIN_BITS'(b);
                trail_next      = b[1:0];
                phase_next      = PH_MHI;
              end
              PH_MHI: begin
                mlen   = len;
                mtrail = trail;
                if (t[7:5] != 3'd0) begin
                  do_match = 1'b1;
                  mdist    = 17'(off) + 17'd1;
                end else if (far == '0) begin
                  fin = 1'b1;
                end else begin
                  do_match = 1'b1;
                  mdist    = 17'(far) + 17'h4000;
                end
              end
              default: phase_next = PH_OP;
            endcase
            if (do_add) begin
              sum      = {1'b0, len} + addv;
              len_next = sum[CNT_BITS-1:0];
              if (sum[CNT_BITS]) err_next = ERR_LENGTH;
            end
            if (do_match) begin
              if (CNT_BITS'(mdist) > produced) begin
                err_next = ERR_LOOKBEHIND;
              end else begin
                copy_rem_next   = mlen;
                match_dist_next = mdist[WIN_BITS-1:0];
                trail_next      = mtrail;
                len_next        = CNT_BITS'(mtrail);
                phase_next      = (mtrail != 2'd0) ? PH_LIT_TRAIL : PH_OP;
              end
            end
            if (fin) begin
              finished_next = 1'b1;
              if (!word.last_byte) err_next = ERR_NOT_CONSUMED;
            end else if (word.last_byte && err_next == ERR_NONE) begin
              err_next = ERR_OVERRUN;
            end
          end
        end else if (word.command == CMD_COPY) begin
          if (copy_rem == '0) begin
            err_next = ERR_MISUSE;
          end else if (produced >= CNT_MAX) begin
            err_next = ERR_LENGTH;
          end else begin
            emit          = 1'b1;
            from_mem      = 1'b1;
            produced_next = produced + 1'b1;
            copy_rem_next = copy_rem - 1'b1;
          end
        end else begin
          err_next = ERR_MISUSE;
        end
      end
    end
  end

  always_comb begin
    pres.out_valid  = emit;
    pres.from_mem   = from_mem;
    pres.lit_byte   = word.in_byte;
    pres.rd_addr    = produced[WIN_BITS-1:0] - match_dist;
    pres.wr_addr    = produced[WIN_BITS-1:0];
    pres.want_input = !finished_next && err_next == ERR_NONE && copy_rem_next == '0;
    pres.done_res   = finished_next;
    pres.error_code = err_next;
    pres.out_count  = produced_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      produced   <= '0;
      phase      <= PH_FIRST;
      len        <= '0;
      match_dist <= '0;
      copy_rem   <= '0;
      trail      <= '0;
      opcode     <= '0;
      finished   <= 1'b0;
      err        <= ERR_NONE;
    end else begin
      produced   <= produced_next;
      phase      <= phase_next;
      len        <= len_next;
      match_dist <= match_dist_next;
      copy_rem   <= copy_rem_next;
      trail      <= trail_next;
      opcode     <= opcode_next;
      finished   <= finished_next;
      err        <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_copy_not_done: assert property (@(posedge clk) disable iff (rst)
    copy_rem != '0 |-> !finished)
    else $error("copy pending after end marker");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err != ERR_NONE && !(acc && word.command == CMD_START) |=> err == $past(err))
    else $error("latched error changed");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    acc && word.command != CMD_START |=>
      produced == $past(produced) || produced == $past(produced) + 1'b1)
    else $error("produced count jumped");
`endif

endmodule

[rtl/lzo_hist.sv]
// History window memory, read stage with write forwarding, and output register.
// Depends on lzo_pkg.
module lzo_hist import lzo_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  acc,
  input  pres_t pres,
  output logic  ready,
  output logic  res_valid,
  input  logic  res_stall,
  output res_t  res_word
);

  logic [7:0]  mem [2**WIN_BITS];
  logic [7:0]  rdata, fwd_data, s2_byte;
  logic        fwd_hit, s2_v, s2_go, wr_en;
  pres_t       s2;

  assign s2_go = !res_valid || !res_stall;
  assign ready = !s2_v || s2_go;
  assign wr_en = s2_v && s2_go && s2.out_valid;

  always_comb begin
    if (!s2.out_valid) s2_byte = 8'd0;
    else if (!s2.from_mem) s2_byte = s2.lit_byte;
    else if (fwd_hit) s2_byte = fwd_data;
    else s2_byte = rdata;
  end

  always_ff @(posedge clk) begin
    if (acc) rdata <= mem[pres.rd_addr];
    if (wr_en) mem[s2.wr_addr] <= s2_byte;
  end

  // catch the byte written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_hit  <= wr_en && s2.wr_addr == pres.rd_addr;
      fwd_data <= s2_byte;
      s2       <= pres;
    end
    if (s2_v && s2_go) begin
      res_word.out_valid  <= s2.out_valid;
      res_word.out_byte   <= s2_byte;
      res_word.want_input <= s2.want_input;
      res_word.done_res   <= s2.done_res;
      res_word.error_code <= s2.error_code;
      res_word.out_count  <= s2.out_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (acc) s2_v <= 1'b1;
      else if (s2_go) s2_v <= 1'b0;
      if (s2_go) res_valid <= s2_v;
    end
  end

endmodule

[rtl/lzo1x_stream_decompressor.sv]
// An accepted word goes through stage s2 to the res_word register; one word
// per cycle while res_stall does not hold the output, compressed bytes and copy
// ticks alike; the history memory gives one read and one write per cycle, distance one forwarded.
// Reset clears block state and pipeline valids; history memory is not cleared.
// Depends on lzo_pkg, lzo_parse, lzo_hist.
module lzo1x_stream_decompressor import lzo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd_word,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_word
);

  logic  ready, acc;
  pres_t pres;

  assign acc       = cmd_valid && ready;
  assign cmd_stall = !ready;

  lzo_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .word (cmd_word),
    .pres (pres)
  );

  lzo_hist u_hist (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .pres      (pres),
    .ready     (ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule
